// ----- sv/rgbhsv_pkg.sv -----
// Package for the RGB to HSV converter: field widths, hue scaling constants
// and the pipeline payload type. Depends on nothing.
package rgbhsv_pkg;

    localparam int unsigned CHAN_W       = 8;
    localparam int unsigned HUE_W        = 15;
    localparam int unsigned HUE_FRAC_DEF = 6;
    localparam int unsigned HUE_FRAC_MAX = 10;
    // Numerators never exceed 360 * 2^HUE_FRAC_MAX * 255 < 2^27.
    localparam int unsigned NUM_W        = 27;
    // Quotients are below 2^(NUM_W - 8 + 1): each hue dividend is at most 60 * 2^HUE_FRAC_MAX times its divisor.
    localparam int unsigned QUO_W        = 20;

    typedef struct packed {
        logic [NUM_W-1:0]  hue_rem;
        logic [QUO_W-1:0]  hue_quo;
        logic [NUM_W-1:0]  hue_base;
        logic [CHAN_W-1:0] hue_div;
        logic [15:0]       sat_rem;
        logic [CHAN_W-1:0] sat_quo;
        logic [CHAN_W-1:0] sat_div;
        logic [CHAN_W-1:0] value;
        logic              gray;
    } t_cell_data;

endpackage

// ----- sv/rgbhsv_cell.sv -----
// One restoring division cell: produces one hue quotient bit and, in the
// last eight cells, one saturation quotient bit. Depends on rgbhsv_pkg.
module rgbhsv_cell #(
    parameter int unsigned HUE_BIT = 0,
    parameter int unsigned SAT_BIT = 0,
    parameter bit          DO_SAT  = 1'b0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  rgbhsv_pkg::t_cell_data  i_data,
    output logic                    o_valid,
    output rgbhsv_pkg::t_cell_data  o_data
);

    localparam int unsigned NW = rgbhsv_pkg::NUM_W;

    rgbhsv_pkg::t_cell_data r_data, n_data;
    logic                   r_valid;
    logic [NW+rgbhsv_pkg::CHAN_W-1:0] w_hue_sub;
    logic [16+rgbhsv_pkg::CHAN_W:0]   w_sat_sub;

    always_comb begin
        n_data    = i_data;
        w_hue_sub = {{rgbhsv_pkg::CHAN_W{1'b0}}, i_data.hue_rem};
        w_sat_sub = '0;
        // Compare remainder against divisor shifted to this quotient bit.
        if (w_hue_sub >= ({{NW{1'b0}}, i_data.hue_div} << HUE_BIT)) begin
            n_data.hue_rem = i_data.hue_rem
                - NW'({{NW{1'b0}}, i_data.hue_div} << HUE_BIT);
            n_data.hue_quo[HUE_BIT] = 1'b1;
        end
        if (DO_SAT) begin
            w_sat_sub = {{rgbhsv_pkg::CHAN_W+1{1'b0}}, i_data.sat_rem};
            if (w_sat_sub >= ({{17{1'b0}}, i_data.sat_div} << SAT_BIT)) begin
                n_data.sat_rem = i_data.sat_rem
                    - 16'({{17{1'b0}}, i_data.sat_div} << SAT_BIT);
                n_data.sat_quo[SAT_BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- sv/rgbhsv_front.sv -----
// Input stage: finds max, min and the hue sector, and forms the dividends.
// Depends on rgbhsv_pkg.
module rgbhsv_front #(
    parameter int unsigned HUE_FRAC_BITS = rgbhsv_pkg::HUE_FRAC_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] i_red,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] i_green,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] i_blu,
    output logic                          o_valid,
    output rgbhsv_pkg::t_cell_data        o_data
);

    localparam int unsigned NW = rgbhsv_pkg::NUM_W;
    localparam logic [NW-1:0] SECTOR = NW'(60) << HUE_FRAC_BITS;

    logic [7:0]    w_max, w_min, w_d, w_lo;
    logic [NW-1:0] w_diff, w_num, w_base;
    logic          w_neg;
    rgbhsv_pkg::t_cell_data r_data, n_data;
    logic          r_valid;

    always_comb begin
        w_max = i_red;
        if (i_green > w_max) w_max = i_green;
        if (i_blu > w_max) w_max = i_blu;
        w_min = i_red;
        if (i_green < w_min) w_min = i_green;
        if (i_blu < w_min) w_min = i_blu;
        w_d = w_max - w_min;
        // Hue = base + floor(SECTOR*(a-b)/d); a negative offset borrows one
        // sector's worth of d so the dividend stays positive.
        if (i_red == w_max) begin
            w_neg  = i_green < i_blu;
            w_lo   = w_neg ? (i_blu - i_green) : (i_green - i_blu);
            w_base = '0;
        end else if (i_green == w_max) begin
            w_neg  = i_blu < i_red;
            w_lo   = w_neg ? (i_red - i_blu) : (i_blu - i_red);
            w_base = SECTOR << 1;
        end else begin
            w_neg  = i_red < i_green;
            w_lo   = w_neg ? (i_green - i_red) : (i_red - i_green);
            w_base = SECTOR << 2;
        end
        w_diff = SECTOR * NW'(w_lo);
        if (w_neg) begin
            // floor(-x/d) = -ceil(x/d); dividend SECTOR*d - x, base - SECTOR
            w_num  = SECTOR * NW'(w_d) - w_diff;
            w_base = (w_base == '0) ? (SECTOR * NW'(5)) : (w_base - SECTOR);
        end else begin
            w_num = w_diff;
        end
        n_data          = '0;
        n_data.hue_rem  = w_num;
        n_data.hue_base = w_base;
        n_data.hue_div  = w_d;
        n_data.sat_rem  = 16'(w_d) * 16'd255;
        n_data.sat_div  = w_max;
        n_data.value    = w_max;
        n_data.gray     = (w_d == '0);
        if (w_d == '0) begin
            n_data.hue_div = 8'd1;
            n_data.sat_div = 8'd1;
            n_data.hue_rem = '0;
            n_data.sat_rem = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- sv/rgb_to_hsv_convert_top.sv -----
// Top level of the RGB to HSV converter: front stage, a row of division
// cells and the output register. Depends on rgbhsv_pkg and its submodules.
//
// One pixel is accepted every clock unless the pipe is stalled. Each pixel
// passes through an input stage, then a row of restoring division cells
// that each resolve one hue quotient bit (and one saturation bit in the
// last eight), then an output register. The whole pipe advances when the
// output register is empty or being read, so i_ready low with a result held stalls it.
module rgb_to_hsv_convert_top #(
    parameter int unsigned HUE_FRAC_BITS = rgbhsv_pkg::HUE_FRAC_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] i_red,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] i_green,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] i_blu,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rgbhsv_pkg::HUE_W-1:0]  o_hue,
    output logic [rgbhsv_pkg::CHAN_W-1:0] o_saturation,
    output logic [rgbhsv_pkg::CHAN_W-1:0] o_value
);

    localparam int unsigned NC = rgbhsv_pkg::QUO_W;

    logic                   w_en;
    logic                   w_valid [NC+1];
    rgbhsv_pkg::t_cell_data w_data  [NC+1];
    logic [rgbhsv_pkg::NUM_W-1:0] w_hue;
    logic                   r_valid;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    rgbhsv_front #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blu   (i_blu),
        .o_valid (w_valid[0]),
        .o_data  (w_data[0])
    );

    for (genvar k = 0; k < NC; k++) begin : g_cell
        rgbhsv_cell #(
            .HUE_BIT (NC - 1 - k),
            .SAT_BIT ((NC - 1 - k) % 8),
            .DO_SAT  (k >= NC - 8)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    assign w_hue = w_data[NC].hue_base
        + {{(rgbhsv_pkg::NUM_W - NC){1'b0}}, w_data[NC].hue_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_valid[NC];
        end
        if (w_en) begin
            o_hue        <= w_data[NC].gray ? '0 : w_hue[rgbhsv_pkg::HUE_W-1:0];
            o_saturation <= w_data[NC].gray ? '0 : w_data[NC].sat_quo;
            o_value      <= w_data[NC].value;
        end
    end

    assign o_valid = r_valid;

endmodule
